[hw/rtl/grid_neighbour_sector_scan_top_defines.svh]
// Assertion macros shared by the grid neighbourhood scan RTL.
// Depends on the asserting module having i_clk and i_rst_n in scope.
`ifndef GRID_NEIGHBOUR_SECTOR_SCAN_TOP_DEFINES_SVH
`define GRID_NEIGHBOUR_SECTOR_SCAN_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GNSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GNSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gnss_pkg.sv]
// Package for the grid neighbourhood scan: item types, codes, controller links.
// No dependencies.
`timescale 1ns / 1ps
package gnss_pkg;

    localparam int unsigned GRID_DIM  = 256;
    localparam logic [1:0]  MAX_RANGE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] CFG_VIEW_RADIUS  = 2'd2;
    localparam logic [1:0] CFG_LUMP_MODE    = 2'd3;

    // Request command codes
    localparam logic CMD_VIEW = 1'b0;
    localparam logic CMD_HIT  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_ZERO_RAD = 2'd2
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [15:0] sector_id;
        logic [1:0]  range;
    } t_req;

    typedef struct packed {
        logic [15:0] cell_out;
        t_status     status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [8:0] row_count;
        logic [8:0] column_count;
        logic [1:0] view_radius;
        logic       lump_mode;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    bounds;
        logic    prep;
        logic    emit_err;
        t_status err_code;
        logic    emit_centre;
        logic    scan;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic outside;
        logic zero_rad;
        logic div_done;
        logic hit;
        logic last_one;
    } t_stat;

    function automatic logic [8:0] clamp_extent(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (v > 9'(GRID_DIM)) begin
            r = 9'(GRID_DIM);
        end
        return r;
    endfunction

endpackage

[hw/rtl/gnss_ctrl.sv]
// Sequencer for the grid neighbourhood scan: check, divide, bound, emit.
// Depends on gnss_pkg; drives gnss_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps
module gnss_ctrl
    import gnss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_BOUNDS,
        S_PREP,
        S_CENTRE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = '0;
        o_cmd.err_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                    n_busy     = 1'b1;
                end
            end
            S_CHECK: begin
                priority if (i_stat.outside) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = ST_OUTSIDE;
                    n_state        = S_IDLE;
                    n_busy         = 1'b0;
                end else if (i_stat.zero_rad) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = ST_ZERO_RAD;
                    n_state        = S_IDLE;
                    n_busy         = 1'b0;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_BOUNDS;
                end
            end
            S_BOUNDS: begin
                o_cmd.bounds = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.hit ? S_CENTRE : S_SCAN;
            end
            S_CENTRE: begin
                o_cmd.emit_centre = 1'b1;
                if (i_stat.last_one) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                // the datapath emits only when the cell is not the skipped centre
                if (i_stat.last_one) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

[hw/rtl/gnss_dp.sv]
// Datapath for the grid neighbourhood scan: id divider, bounds, cell walker.
// Depends on gnss_pkg; sequenced by gnss_ctrl.
`timescale 1ns / 1ps
module gnss_dp
    import gnss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_res_valid
);

    logic        r_cmd;
    logic [15:0] r_id;
    logic [1:0]  r_rad;
    logic [8:0]  r_rows;
    logic [8:0]  r_cols;
    logic [7:0]  r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_div_cnt;
    logic [7:0]  r_left, r_right, r_bot, r_top;
    logic [5:0]  r_count;
    logic [7:0]  r_scan_x;
    logic [15:0] r_cell;
    logic [15:0] r_row_start;
    t_res        r_res;
    logic        r_res_valid;

    logic [1:0]  req_rad;
    logic [17:0] total;
    logic [8:0]  div_trial;
    logic        div_sub;
    logic [8:0]  x_sum, y_sum;
    logic [2:0]  width, height;
    logic [16:0] base_prod;
    logic        skip;

    always_comb begin
        req_rad = (i_req.cmd == CMD_HIT) ? i_req.range : i_cfg.view_radius;
        if (req_rad > MAX_RANGE) begin
            req_rad = MAX_RANGE;
        end
    end

    assign total     = r_rows * r_cols;
    assign div_trial = {r_rem, r_quo[15]};
    assign div_sub   = (div_trial >= r_rows);
    assign x_sum     = {1'b0, r_rem} + {7'd0, r_rad};
    assign y_sum     = {1'b0, r_quo[7:0]} + {7'd0, r_rad};
    assign width     = 3'(r_right - r_left) + 3'd1;
    assign height    = 3'(r_top - r_bot) + 3'd1;
    assign base_prod = r_bot * r_rows;
    assign skip      = (r_cmd == CMD_HIT) && (r_cell == r_id);

    always_comb begin
        o_stat.outside  = ({2'd0, r_id} >= total);
        o_stat.zero_rad = (r_rad == 2'd0);
        o_stat.div_done = (r_div_cnt == 4'd15);
        o_stat.hit      = (r_cmd == CMD_HIT);
        // in the scan, only a real emission may end the request
        o_stat.last_one = (r_count == 6'd1) && !(i_cmd.scan && skip);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_req.cmd;
            r_id      <= i_req.sector_id;
            r_rad     <= req_rad;
            r_rows    <= i_cfg.lump_mode ? 9'd1 : clamp_extent(i_cfg.row_count);
            r_cols    <= i_cfg.lump_mode ? 9'd1 : clamp_extent(i_cfg.column_count);
            r_rem     <= 8'd0;
            r_quo     <= i_req.sector_id;
            r_div_cnt <= 4'd0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_sub ? 8'(div_trial - r_rows) : div_trial[7:0];
            r_quo     <= {r_quo[14:0], div_sub};
            r_div_cnt <= r_div_cnt + 4'd1;
        end
        if (i_cmd.bounds) begin
            r_left  <= (r_rem >= {6'd0, r_rad}) ? r_rem - {6'd0, r_rad} : 8'd0;
            r_right <= (x_sum >= r_rows) ? 8'(r_rows - 9'd1) : x_sum[7:0];
            r_bot   <= (r_quo[7:0] >= {6'd0, r_rad}) ? r_quo[7:0] - {6'd0, r_rad} : 8'd0;
            r_top   <= (y_sum >= r_cols) ? 8'(r_cols - 9'd1) : y_sum[7:0];
        end
        if (i_cmd.prep) begin
            r_count     <= 6'(width * height);
            r_scan_x    <= r_left;
            r_row_start <= 16'(base_prod + {9'd0, r_left});
            r_cell      <= 16'(base_prod + {9'd0, r_left});
        end
        if (i_cmd.emit_centre) begin
            r_count <= r_count - 6'd1;
        end
        if (i_cmd.scan) begin
            if (!skip) begin
                r_count <= r_count - 6'd1;
            end
            // advance along the row, wrap to the next row at the right bound
            if (r_scan_x == r_right) begin
                r_scan_x    <= r_left;
                r_row_start <= 16'(r_row_start + r_rows);
                r_cell      <= 16'(r_row_start + r_rows);
            end else begin
                r_scan_x <= r_scan_x + 8'd1;
                r_cell   <= r_cell + 16'd1;
            end
        end
        // result payload
        if (i_cmd.emit_err) begin
            r_res.cell_out <= 16'd0;
            r_res.status   <= i_cmd.err_code;
            r_res.last     <= 1'b1;
        end else if (i_cmd.emit_centre) begin
            r_res.cell_out <= r_id;
            r_res.status   <= ST_OK;
            r_res.last     <= (r_count == 6'd1);
        end else if (i_cmd.scan) begin
            r_res.cell_out <= r_cell;
            r_res.status   <= ST_OK;
            r_res.last     <= (r_count == 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit_err || i_cmd.emit_centre || (i_cmd.scan && !skip);
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

[hw/rtl/grid_neighbour_sector_scan_top.sv]
// Top level of the grid neighbourhood scan: configuration registers and wiring.
// Depends on gnss_pkg, gnss_ctrl, gnss_dp and the assertion macro header.
//
// Use:
//   Configure row_count, column_count, view_radius and lump_mode through the
//   write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
//   Present a request item on i_req with start; it is taken at an edge where
//   start is high and busy is low. busy stays high until the final result.
//   Results come out one per strobe on o_res/o_res_valid, each valid for one
//   cycle; o_res.last marks the final item of a request. The receiver has no
//   back-pressure, so every strobe must be taken as it comes.
// Sequence:
//   Error requests (centre outside grid, zero radius) end after the check
//   state and give one item. Valid requests pass through the check state,
//   the bit-serial id divider and the bounds and base states, then the walker
//   visits one cell of the clamped square per cycle (plus the centre first on a
//   hit request, whose skipped slot in the scan gives no item); every item
//   passes through the result register.
//   A new request is taken only once busy has dropped.
// Reset:
//   Synchronous, active low: registers return to row_count 1, column_count 1,
//   view_radius 1, lump_mode 0; the sequencer returns to idle.
`timescale 1ns / 1ps
`include "grid_neighbour_sector_scan_top_defines.svh"
module grid_neighbour_sector_scan_top
    import gnss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output t_res       o_res,
    output logic       o_res_valid,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    // Hold configuration; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count    <= 9'd1;
            r_cfg.column_count <= 9'd1;
            r_cfg.view_radius  <= 2'd1;
            r_cfg.lump_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_COUNT:    r_cfg.row_count    <= i_cfg_data;
                CFG_COLUMN_COUNT: r_cfg.column_count <= i_cfg_data;
                CFG_VIEW_RADIUS:  r_cfg.view_radius  <= i_cfg_data[1:0];
                CFG_LUMP_MODE:    r_cfg.lump_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gnss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gnss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

    // An accepted request must hold the block busy.
    `GNSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
    // The final item leaves the block idle, any other item keeps it busy.
    `GNSS_ASSERT_NOW(a_last_idle, o_res_valid && o_res.last, !busy, "busy after final item")
    `GNSS_ASSERT_NOW(a_mid_busy, o_res_valid && !o_res.last, busy, "idle before final item")
    // An error item is always the only item of its request.
    `GNSS_ASSERT_NOW(a_err_last, o_res_valid && (o_res.status != ST_OK), o_res.last,
        "error item not marked last")

endmodule

[tb/tb_grid_neighbour_sector_scan_top.sv]
// Self-checking testbench for grid_neighbour_sector_scan_top: directed and random requests.
// A clocked driver and monitor run around an in-bench neighbourhood predictor.
// Depends on gnss_pkg and the grid_neighbour_sector_scan_top RTL only.
`timescale 1ns / 1ps
module tb_grid_neighbour_sector_scan_top;
    import gnss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    t_res       o_res;
    logic       o_res_valid;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [8:0] i_cfg_data = '0;

    grid_neighbour_sector_scan_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res      (o_res),
        .o_res_valid(o_res_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Requests waiting to be driven, and the cell items they are predicted to give
    t_req pending_requests[$];
    t_res expected_cells[$];

    // Shadow of the configuration registers, tracked from the write port
    logic [8:0] row_count_cfg    = 9'd1;
    logic [8:0] column_count_cfg = 9'd1;
    logic [1:0] view_radius_cfg  = 2'd1;
    logic       lump_mode_cfg    = 1'b0;

    // Clamped square and centre of the last request that scanned
    int unsigned left_edge, right_edge, bottom_edge, top_edge, centre_id;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned gap_left       = 0;
    logic        req_taken      = 1'b0;
    logic        steady_run     = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost item ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_neighbour_sector_scan_top test failed");
            $finish;
        end
    end

    // Zero extents read as one cell, oversized ones as the full grid
    function automatic int unsigned fit_extent(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'(GRID_DIM)) return GRID_DIM;
        return int'(v);
    endfunction

    function automatic int unsigned grid_cells();
        if (lump_mode_cfg) return 1;
        return fit_extent(row_count_cfg) * fit_extent(column_count_cfg);
    endfunction

    function automatic void add_cell(input int unsigned cell_id, input t_status st,
                                     input bit fin);
        t_res r;
        r.cell_out = 16'(cell_id);
        r.status   = st;
        r.last     = fin;
        expected_cells = {expected_cells, r};
    endfunction

    // Work out every cell item one request gives and queue them in order
    function automatic void predict_neighbourhood(input t_req r);
        int unsigned rows, cols, radius, cx, cy, span, n, cell_idx;
        rows   = lump_mode_cfg ? 1 : fit_extent(row_count_cfg);
        cols   = lump_mode_cfg ? 1 : fit_extent(column_count_cfg);
        radius = (r.cmd == CMD_HIT) ? int'(r.range) : int'(view_radius_cfg);
        // The outside check wins over the radius check
        if (int'(r.sector_id) >= rows * cols) begin
            add_cell(0, ST_OUTSIDE, 1'b1);
            return;
        end
        if (radius == 0) begin
            add_cell(0, ST_ZERO_RAD, 1'b1);
            return;
        end
        cx          = r.sector_id % rows;
        cy          = r.sector_id / rows;
        centre_id   = r.sector_id;
        left_edge   = (cx >= radius) ? cx - radius : 0;
        right_edge  = (cx + radius >= rows) ? rows - 1 : cx + radius;
        bottom_edge = (cy >= radius) ? cy - radius : 0;
        top_edge    = (cy + radius >= cols) ? cols - 1 : cy + radius;
        // A hit emits the centre first and skips it in the scan, so the count is the same
        span = (right_edge - left_edge + 1) * (top_edge - bottom_edge + 1);
        n = 0;
        if (r.cmd == CMD_HIT) begin
            n = 1;
            add_cell(centre_id, ST_OK, span == 1);
        end
        for (int unsigned y = bottom_edge; y <= top_edge; y++) begin
            for (int unsigned x = left_edge; x <= right_edge; x++) begin
                cell_idx = y * rows + x;
                if (r.cmd == CMD_HIT && cell_idx == centre_id) continue;
                n++;
                add_cell(cell_idx, ST_OK, n == span);
            end
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [15:0] want,
                                            input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Driver: change inputs on the falling edge; hold start until the item is taken
    always @(negedge i_clk) begin : driver
        logic next_start;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (!start || req_taken) begin
            next_start = 1'b0;
            if (gap_left != 0 && !steady_run) begin
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                i_req <= pending_requests.pop_front();
                next_start = 1'b1;
                // Drop in an idle burst now and then, never in the closing phase
                if (!steady_run && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 19);
            end
        end
        start <= next_start;
    end

    // Monitor: sample on the rising edge, track writes, predict on accept, check results
    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            row_count_cfg    = 9'd1;
            column_count_cfg = 9'd1;
            view_radius_cfg  = 2'd1;
            lump_mode_cfg    = 1'b0;
            req_taken       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROW_COUNT:    row_count_cfg    = i_cfg_data;
                    CFG_COLUMN_COUNT: column_count_cfg = i_cfg_data;
                    CFG_VIEW_RADIUS:  view_radius_cfg  = i_cfg_data[1:0];
                    CFG_LUMP_MODE:    lump_mode_cfg    = i_cfg_data[0];
                    default: ;
                endcase
            end
            req_taken <= start && !busy;
            if (start && !busy) begin
                predict_neighbourhood(i_req);
                accepted_count++;
            end
            if (o_res_valid !== 1'b0) begin
                if (expected_cells.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $display("%0t ns: item with none expected, actual cell %0d status %0d last %0d",
                                 $time, o_res.cell_out, o_res.status, o_res.last);
                end else begin
                    want = expected_cells.pop_front();
                    if (o_res.cell_out !== want.cell_out)
                        report_mismatch("cell_out", want.cell_out, o_res.cell_out);
                    if (o_res.status !== want.status)
                        report_mismatch("status", 16'(want.status), 16'(o_res.status));
                    if (o_res.last !== want.last)
                        report_mismatch("last", 16'(want.last), 16'(o_res.last));
                end
            end
        end
    end

    task automatic queue_item(input logic cmd, input logic [15:0] id, input logic [1:0] rng);
        t_req r;
        r.cmd       = cmd;
        r.sector_id = id;
        r.range     = rng;
        pending_requests = {pending_requests, r};
        queued_count++;
    endtask

    // Hold off until every item is taken and every cell item has come, then settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (accepted_count != queued_count || expected_cells.size() != 0 || busy !== 1'b0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic set_config(input logic [8:0] rows, input logic [8:0] cols,
                              input logic [1:0] radius, input logic lump);
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_VIEW_RADIUS, 9'(radius));
        write_reg(CFG_LUMP_MODE, 9'(lump));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly in-grid centres with a live radius; the rest use ids from the whole range and zero ranges
    task automatic random_phase(input int count);
        int unsigned cells;
        logic [15:0] id;
        logic [1:0]  rng;
        cells = grid_cells();
        repeat (count) begin
            if ($urandom_range(0, 9) < 8) id = 16'($urandom_range(0, cells - 1));
            else id = 16'($urandom_range(0, 65535));
            rng = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            queue_item(1'($urandom_range(0, 1)), id, rng);
        end
        wait_idle();
    endtask

    initial begin : stimulus
        logic [8:0] rows, cols;
        logic [1:0] radius;
        logic       lump;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a one-cell grid with view radius one
        queue_item(CMD_VIEW, 16'd0, 2'd0);
        queue_item(CMD_HIT, 16'd0, 2'd1);      // hit on a single cell: centre only
        queue_item(CMD_HIT, 16'd0, 2'd0);      // zero radius
        queue_item(CMD_VIEW, 16'd1, 2'd3);     // centre outside the grid
        queue_item(CMD_HIT, 16'hFFFF, 2'd0);   // outside takes priority over zero radius
        wait_idle();

        // Full grid, every corner, hit requests at every range and view requests at the configured radius
        set_config(9'd256, 9'd256, 2'd3, 1'b0);
        queue_item(CMD_VIEW, 16'd0, 2'd0);
        queue_item(CMD_VIEW, 16'hFFFF, 2'd0);
        queue_item(CMD_HIT, 16'h8080, 2'd3);
        queue_item(CMD_HIT, 16'd255, 2'd2);
        queue_item(CMD_HIT, 16'hFF00, 2'd1);
        queue_item(CMD_HIT, 16'hFFFF, 2'd0);
        queue_item(CMD_VIEW, 16'h7F7F, 2'd1);
        wait_idle();

        // Small grid with view radius zero; the square spills over every edge
        set_config(9'd5, 9'd4, 2'd0, 1'b0);
        queue_item(CMD_VIEW, 16'd7, 2'd2);
        queue_item(CMD_HIT, 16'd7, 2'd3);
        queue_item(CMD_HIT, 16'd20, 2'd1);
        queue_item(CMD_HIT, 16'd19, 2'd1);
        wait_idle();

        // Lump mode: the map is one cell whatever the extents
        set_config(9'd3, 9'd3, 2'd2, 1'b1);
        queue_item(CMD_VIEW, 16'd0, 2'd0);
        queue_item(CMD_HIT, 16'd0, 2'd3);
        queue_item(CMD_VIEW, 16'd1, 2'd1);
        wait_idle();

        // Zero and oversized extents: one column of the full height
        set_config(9'd0, 9'd511, 2'd1, 1'b0);
        queue_item(CMD_VIEW, 16'd255, 2'd0);
        queue_item(CMD_HIT, 16'd128, 2'd2);
        queue_item(CMD_VIEW, 16'd256, 2'd0);
        wait_idle();

        // Random phases; the last one runs with no idle bursts
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                set_config(9'd256, 9'd256, 2'd3, 1'b0);
            end else if (p == 1) begin
                set_config(9'd511, 9'd0, 2'd2, 1'b0);
            end else begin
                rows   = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(1, 12));
                cols   = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(1, 12));
                radius = ($urandom_range(0, 5) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                lump   = ($urandom_range(0, 7) == 0);
                set_config(rows, cols, radius, lump);
            end
            if (p == 7) steady_run = 1'b1;
            random_phase(45);
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("grid_neighbour_sector_scan_top test passed");
        end else begin
            $display("grid_neighbour_sector_scan_top test failed");
        end
        $finish;
    end

endmodule
